/* src/sfl_alloc_pkg.sv */
// Package for the sub-pool free-list slot allocator.
// Holds the item structs, status codes, sequencer states and fixed sizes.
// No dependencies.
`default_nettype none

package sfl_alloc_pkg;

  localparam int NUM_SUB_POOLS = 8;
  localparam int SUB_POOL_SIZE = 16;

  localparam int POOL_W  = $clog2(NUM_SUB_POOLS);
  localparam int SLOT_W  = $clog2(SUB_POOL_SIZE);
  localparam int CNT_W   = $clog2(SUB_POOL_SIZE + 1);
  localparam int ADDR_W  = POOL_W + SLOT_W;
  localparam int DEPTH   = NUM_SUB_POOLS * SUB_POOL_SIZE;
  localparam int LIMIT_W = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK            = 2'd0;
  localparam logic [1:0] STATUS_DEPLETED      = 2'd1;
  localparam logic [1:0] STATUS_FREE_INACTIVE = 2'd2;
  localparam logic [1:0] STATUS_FREE_FULL     = 2'd3;

  typedef struct packed {
    logic              opcode;
    logic [POOL_W-1:0] free_sub_pool;
    logic [SLOT_W-1:0] free_slot;
  } sfl_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POOL_W-1:0] given_sub_pool;
    logic [SLOT_W-1:0] given_slot;
  } sfl_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_READ,
    ST_FREE,
    ST_DONE
  } sfl_state_t;

endpackage

`default_nettype wire

/* src/subpool_free_list_id_allocator_top.sv */
// Sub-pool free-list slot allocator, top level.
// Depends on sfl_alloc_pkg for item types, status codes and sequencer states.
//
// Usage:
//   Request channel (in_valid / in_stall / in_data): an item is taken at a
//   clock edge with in_valid high and in_stall low. opcode 0 allocates a slot,
//   opcode 1 frees free_slot of free_sub_pool. One request is worked at a time;
//   in_stall is high from the edge after acceptance until the result is parked.
//   Result channel (out_valid / out_stall / out_data): one result per request,
//   held in an output register until taken (out_valid high, out_stall low).
//   A new request may be accepted while that result still waits.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes sub_pool_limit;
//   cfg_ready is always high. Write only while no request is in flight.
// Sequence:
//   Free: the FREE step checks the sub-pool and pushes the slot, then DONE parks the result.
//   Allocate: one sub-pool is examined per cycle by a single compare unit,
//   in a scan of up to 8 sub-pools; the stack read and the result follow.
//   The registered read of the stack memory (one read port) sets the POP and
//   READ steps.
// Reset (rst, synchronous): all sub-pools inactive with zero free count,
//   limit back to 8, output register empty, in_stall high while rst is high.
//   Stack contents need no clearing:
//   a per-entry valid bit, cleared by row on activation, makes an unwritten
//   entry read as its own position (the freshly filled stack).
// Stall: while out_stall holds a result, a finished next result waits inside
//   the sequencer (ST_DONE) and no further request is taken.
`default_nettype none

module subpool_free_list_id_allocator_top
  import sfl_alloc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sfl_req_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sfl_rsp_t                out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  localparam logic [POOL_W-1:0] LAST_POOL = POOL_W'(NUM_SUB_POOLS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SUB_POOL_SIZE);

  sfl_state_t state, state_next;

  logic [LIMIT_W-1:0]  limit;
  sfl_req_t            req;
  sfl_rsp_t            res;
  logic [POOL_W-1:0]   idx;
  logic                cand_found;
  logic [POOL_W-1:0]   cand;
  logic [POOL_W-1:0]   pop_pool;
  logic [SLOT_W-1:0]   pos;

  logic [NUM_SUB_POOLS-1:0] active;
  logic [CNT_W-1:0]         free_count [NUM_SUB_POOLS];

  // stack memory and per-entry written flags
  logic [SLOT_W-1:0]   stack_mem [DEPTH];
  logic [SLOT_W-1:0]   rd_data;
  logic                rd_written;
  logic [DEPTH-1:0]    written;

  // shared compare unit: one sub-pool per cycle
  logic [POOL_W-1:0]   cmp_pool;
  logic                cmp_active;
  logic [CNT_W-1:0]    cmp_cnt;
  logic                scan_hit;
  logic                cand_here;
  logic                cand_any;
  logic [POOL_W-1:0]   cand_sel;
  logic                scan_last;

  logic [CNT_W-1:0]    pop_cnt_m1;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = rst || (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    cmp_pool   = (state == ST_FREE) ? req.free_sub_pool : idx;
    cmp_active = active[cmp_pool];
    cmp_cnt    = free_count[cmp_pool];
    scan_hit   = cmp_active && (cmp_cnt != '0);
    cand_here  = !cmp_active && ({1'b0, idx} < limit) && !cand_found;
    cand_any   = cand_found || cand_here;
    cand_sel   = cand_found ? cand : idx;
    scan_last  = (idx == LAST_POOL);
    pop_cnt_m1 = free_count[pop_pool] - CNT_W'(1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.opcode == OP_FREE) ? ST_FREE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_next = ST_POP;
        end else if (scan_last) begin
          state_next = cand_any ? ST_POP : ST_DONE;
        end
      end
      ST_POP:  state_next = ST_READ;
      ST_READ: state_next = ST_DONE;
      ST_FREE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      cand_found <= 1'b0;
      written    <= '0;
      for (int i = 0; i < NUM_SUB_POOLS; i++) begin
        free_count[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            idx        <= '0;
            cand_found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            pop_pool <= idx;
          end else begin
            if (cand_here) begin
              cand       <= idx;
              cand_found <= 1'b1;
            end
            if (scan_last) begin
              if (cand_any) begin
                // bring up a fresh sub-pool: full stack, slot N-1 on top
                active[cand_sel]                          <= 1'b1;
                free_count[cand_sel]                      <= FULL_CNT;
                written[{cand_sel, SLOT_W'(0)} +: SUB_POOL_SIZE] <= '0;
                pop_pool                                  <= cand_sel;
              end else begin
                res <= '{status: STATUS_DEPLETED, given_sub_pool: '0, given_slot: '0};
              end
            end else begin
              idx <= idx + POOL_W'(1);
            end
          end
        end
        ST_POP: begin
          free_count[pop_pool] <= pop_cnt_m1;
          pos                  <= pop_cnt_m1[SLOT_W-1:0];
        end
        ST_READ: begin
          res.status         <= STATUS_OK;
          res.given_sub_pool <= pop_pool;
          res.given_slot     <= rd_written ? rd_data : pos;
        end
        ST_FREE: begin
          res.given_sub_pool <= '0;
          res.given_slot     <= '0;
          if (!cmp_active) begin
            res.status <= STATUS_FREE_INACTIVE;
          end else if (cmp_cnt == FULL_CNT) begin
            res.status <= STATUS_FREE_FULL;
          end else begin
            res.status <= STATUS_OK;
            written[{req.free_sub_pool, cmp_cnt[SLOT_W-1:0]}] <= 1'b1;
            if (cmp_cnt == FULL_CNT - CNT_W'(1)) begin
              // whole sub-pool back: retire it
              active[req.free_sub_pool]     <= 1'b0;
              free_count[req.free_sub_pool] <= '0;
            end else begin
              free_count[req.free_sub_pool] <= cmp_cnt + CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_FREE && cmp_active && cmp_cnt != FULL_CNT) begin
      stack_mem[{req.free_sub_pool, cmp_cnt[SLOT_W-1:0]}] <= req.free_slot;
    end
    if (state == ST_POP) begin
      rd_data    <= stack_mem[{pop_pool, pop_cnt_m1[SLOT_W-1:0]}];
      rd_written <= written[{pop_pool, pop_cnt_m1[SLOT_W-1:0]}];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire
